@@ hw/rtl/dsleb_pkg.sv @@
// ----------------------------------------------------------------------------
// Delta table search package
// Shared widths, constants, register indexes and payload types for the
// signed LEB128 delta table search unit.
// ----------------------------------------------------------------------------
package dsleb_pkg;

    localparam int VALUE_W      = 64;
    localparam int ROW_INDEX_W  = 9;
    localparam int ROW_COUNT_W  = 10;
    localparam int ADJUST_W     = 4;
    localparam int SHIFT_W      = 7;
    localparam int CFG_INDEX_W  = 3;
    localparam int BYTE_W       = 8;

    localparam int DEF_COLUMNS  = 2;
    localparam int DEF_MAX_ROWS = 512;

    localparam logic [SHIFT_W-1:0] SHIFT_STEP  = 7'd7;
    localparam logic [SHIFT_W-1:0] SHIFT_CAP   = 7'd70;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 7'd64;

    localparam logic [BYTE_W-1:0] LEB_PAYLOAD_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] LEB_MORE_MASK    = 8'h80;
    localparam logic [BYTE_W-1:0] LEB_SIGN_MASK    = 8'h40;

    localparam logic [ADJUST_W-1:0] ADJUST_RESET = 4'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GUEST_PC_BASE       = 3'd0,
        CFG_HOST_PC_BASE        = 3'd1,
        CFG_SEARCH_HOST_ADDRESS = 3'd2,
        CFG_RETURN_ADJUST       = 3'd3,
        CFG_ROW_COUNT           = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] table_byte;
        logic              start_search;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [VALUE_W-1:0]     guest_address;
        logic [VALUE_W-1:0]     extra_word;
        logic [ROW_INDEX_W-1:0] row_index;
    } out_item_t;

    typedef struct packed {
        logic fire;
        logic start;
        logic live;
    } dec_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } leb_value_t;

endpackage

@@ hw/rtl/delta_sleb128_host_pc_search_unit.sv @@
// ----------------------------------------------------------------------------
// Delta table host address search unit
// A result is registered and presented in the cycle after the request that causes it.
// Throughput: one table byte per cycle; the only stall is a full result
// register that the consumer has not taken.
// Reset clears the control state, loads the register reset values and leaves
// the unit idle until a request with start_search arrives.
// ----------------------------------------------------------------------------
module delta_sleb128_host_pc_search_unit
    import dsleb_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int LW = (CW > ROW_COUNT_W) ? CW : ROW_COUNT_W;

    logic [VALUE_W-1:0]     guest_base_reg;
    logic [VALUE_W-1:0]     host_base_reg;
    logic [VALUE_W-1:0]     search_reg;
    logic [ADJUST_W-1:0]    adjust_reg;
    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [VALUE_W-1:0]     target;
    logic [CW-1:0]          limit;

    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    logic                   fire;
    dec_ctrl_t              ctrl;
    leb_value_t             leb;
    logic                   res_valid;
    out_item_t              res;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign fire      = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign target    = search_reg - VALUE_W'(adjust_reg);

    always_comb begin
        if (LW'(row_count_reg) < LW'(MAX_ROWS)) begin
            limit = CW'(row_count_reg);
        end else begin
            limit = CW'(MAX_ROWS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guest_base_reg <= '0;
            host_base_reg  <= '0;
            search_reg     <= '0;
            adjust_reg     <= ADJUST_RESET;
            row_count_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_GUEST_PC_BASE:       guest_base_reg <= cfg_data;
                CFG_HOST_PC_BASE:        host_base_reg  <= cfg_data;
                CFG_SEARCH_HOST_ADDRESS: search_reg     <= cfg_data;
                CFG_RETURN_ADJUST:       adjust_reg     <= cfg_data[ADJUST_W-1:0];
                CFG_ROW_COUNT:           row_count_reg  <= cfg_data[ROW_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dsleb_value u_value (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .table_byte (s_data.table_byte),
        .leb        (leb)
    );

    dsleb_track #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .start      (s_data.start_search),
        .guest_base (guest_base_reg),
        .host_base  (host_base_reg),
        .target     (target),
        .limit      (limit),
        .leb        (leb),
        .ctrl       (ctrl),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("Input stalled while the result register could take a result.");

    a_miss_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |->
            (m_data.guest_address == '0 && m_data.extra_word == '0 && m_data.row_index == '0))
        else $error("Not-found result carries nonzero fields.");

    a_empty_table_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_data.start_search && limit == '0) |=> (m_valid && !m_data.found))
        else $error("Start on an empty table did not give a not-found result.");

    a_result_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("Result appeared without an accepted request.");
`endif

endmodule

@@ hw/rtl/dsleb_value.sv @@
// ----------------------------------------------------------------------------
// LEB128 value assembler
// Collects the seven payload bits of each byte into a value and sign-extends
// the value when its last byte arrives.
// ----------------------------------------------------------------------------
module dsleb_value
    import dsleb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dec_ctrl_t           ctrl,
    input  logic [BYTE_W-1:0]   table_byte,
    output leb_value_t          leb
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;

    logic [VALUE_W-1:0] value_eff;
    logic [SHIFT_W-1:0] shift_eff;
    logic [SHIFT_W-1:0] shift_sum;
    logic [SHIFT_W-1:0] shift_sat;
    logic [VALUE_W-1:0] payload_term;
    logic [VALUE_W-1:0] build;
    logic [VALUE_W-1:0] sign_term;
    logic               more;

    always_comb begin
        value_eff    = ctrl.start ? '0 : value_reg;
        shift_eff    = ctrl.start ? '0 : shift_reg;
        shift_sum    = shift_eff + SHIFT_STEP;
        shift_sat    = (shift_sum > SHIFT_CAP) ? SHIFT_CAP : shift_sum;
        payload_term = (shift_eff < SHIFT_LIMIT)
                     ? (VALUE_W'(table_byte & LEB_PAYLOAD_MASK) << shift_eff[5:0]) : '0;
        build        = value_eff | payload_term;
        more         = |(table_byte & LEB_MORE_MASK);
        sign_term    = ((shift_sat < SHIFT_LIMIT) && (|(table_byte & LEB_SIGN_MASK)))
                     ? ({VALUE_W{1'b1}} << shift_sat[5:0]) : '0;

        value_next = value_reg;
        shift_next = shift_reg;
        leb.done   = 1'b0;
        leb.value  = build | sign_term;

        if (ctrl.fire && ctrl.live) begin
            if (more) begin
                value_next = build;
                shift_next = shift_sat;
            end else begin
                leb.done   = 1'b1;
                value_next = '0;
                shift_next = '0;
            end
        end else if (ctrl.fire && ctrl.start) begin
            value_next = '0;
            shift_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            value_reg <= '0;
        end else begin
            shift_reg <= shift_next;
            value_reg <= value_next;
        end
    end

endmodule

@@ hw/rtl/dsleb_track.sv @@
// ----------------------------------------------------------------------------
// Row tracker
// Holds the column and host accumulators, the column and row counters and
// the verdict flag, and forms the search result.
// ----------------------------------------------------------------------------
module dsleb_track
    import dsleb_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int CW = $clog2(MAX_ROWS + 1)
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic               start,
    input  logic [VALUE_W-1:0] guest_base,
    input  logic [VALUE_W-1:0] host_base,
    input  logic [VALUE_W-1:0] target,
    input  logic [CW-1:0]      limit,
    input  leb_value_t         leb,
    output dec_ctrl_t          ctrl,
    output logic               res_valid,
    output out_item_t          res
);

    localparam int IW = (CW > ROW_INDEX_W) ? CW : ROW_INDEX_W;

    logic [VALUE_W-1:0] col0_reg, col0_next;
    logic [VALUE_W-1:0] col1_reg, col1_next;
    logic [VALUE_W-1:0] host_reg, host_next;
    logic [CW-1:0]      rows_reg, rows_next;
    logic [1:0]         col_idx_reg, col_idx_next;
    logic               verdict_reg, verdict_next;

    logic [VALUE_W-1:0] col0_eff, col1_eff, host_eff, host_sum;
    logic [CW-1:0]      rows_eff, rows_inc;
    logic [1:0]         col_idx_eff;
    logic [IW-1:0]      index_wide;
    logic               early_miss;
    logic               live;
    logic               host_row;
    logic               hit;
    logic               rows_done;

    always_comb begin
        early_miss  = start && ((target < host_base) || (limit == '0));
        live        = start ? !early_miss : !verdict_reg;
        ctrl.fire   = fire;
        ctrl.start  = start;
        ctrl.live   = live;

        col0_eff    = start ? guest_base : col0_reg;
        col1_eff    = start ? '0 : col1_reg;
        host_eff    = start ? host_base : host_reg;
        rows_eff    = start ? '0 : rows_reg;
        col_idx_eff = start ? '0 : col_idx_reg;

        host_sum    = host_eff + leb.value;
        rows_inc    = rows_eff + CW'(1);
        host_row    = !(col_idx_eff < 2'(COLUMNS));
        hit         = host_sum > target;
        rows_done   = rows_inc >= limit;
        index_wide  = IW'(rows_inc) - IW'(1);

        col0_next    = col0_reg;
        col1_next    = col1_reg;
        host_next    = host_reg;
        rows_next    = rows_reg;
        col_idx_next = col_idx_reg;
        verdict_next = verdict_reg;

        if (fire && start) begin
            col0_next    = col0_eff;
            col1_next    = col1_eff;
            host_next    = host_eff;
            rows_next    = rows_eff;
            col_idx_next = col_idx_eff;
            verdict_next = early_miss;
        end

        if (fire && live && leb.done) begin
            if (!host_row) begin
                if (col_idx_eff[0]) begin
                    col1_next = col1_eff + leb.value;
                end else begin
                    col0_next = col0_eff + leb.value;
                end
                col_idx_next = col_idx_eff + 2'd1;
            end else begin
                host_next    = host_sum;
                col_idx_next = '0;
                rows_next    = rows_inc;
                if (hit || rows_done) begin
                    verdict_next = 1'b1;
                end
            end
        end

        res_valid = fire && (early_miss || (live && leb.done && host_row && (hit || rows_done)));

        res.found         = !early_miss && hit;
        res.guest_address = res.found ? col0_eff : '0;
        res.extra_word    = (res.found && (COLUMNS >= 2)) ? col1_eff : '0;
        res.row_index     = res.found ? index_wide[ROW_INDEX_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= '0;
            col_idx_reg <= '0;
            verdict_reg <= 1'b1;
        end else begin
            rows_reg    <= rows_next;
            col_idx_reg <= col_idx_next;
            verdict_reg <= verdict_next;
        end
    end

    always_ff @(posedge aclk) begin
        col0_reg <= col0_next;
        col1_reg <= col1_next;
        host_reg <= host_next;
    end

endmodule
